FILE: design/chip8_control_alu_execute_assert.svh
// assertion macros used by the checker file of the execute block
// no dependencies; taken in by `include
`ifndef CHIP8_CONTROL_ALU_EXECUTE_ASSERT_SVH
`define CHIP8_CONTROL_ALU_EXECUTE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define C8X_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled while in reset
`define C8X_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: design/c8x_pkg.sv
// shared constants, codes and types of the chip8 execute block
// no dependencies; used by the interface, data path, top level and checker through scoped names
`default_nettype none

package c8x_pkg;

    // machine memory size and return store geometry
    localparam int MEMORY_BYTES = 4096;
    localparam int STORE_DEPTH  = MEMORY_BYTES / 2;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);

    // field widths
    localparam int PC_W     = 16;
    localparam int SIZE_W   = 13;
    localparam int REG_W    = 8;
    localparam int RIDX_W   = 4;
    localparam int ADDR_W   = 12;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 4;
    localparam int NREGS    = 16;

    localparam logic [RIDX_W-1:0] FLAG_REG   = 4'd15;
    localparam logic [PC_W-1:0]   STEP_BYTES = 16'd2;
    localparam logic [SIZE_W-1:0] STEP_SIZE  = 13'd2;
    // highest stack top that still has room for one more entry
    localparam logic [PC_W:0]     STACK_LIMIT = 17'(MEMORY_BYTES - 2);

    typedef enum logic [OP_W-1:0] {
        OP_RET     = 4'd0,
        OP_JUMP    = 4'd1,
        OP_CALL    = 4'd2,
        OP_SKEQ_NN = 4'd3,
        OP_SKNE_NN = 4'd4,
        OP_SKEQ_VY = 4'd5,
        OP_SKNE_VY = 4'd6,
        OP_LOAD    = 4'd7,
        OP_ADD_NN  = 4'd8,
        OP_MOVE    = 4'd9,
        OP_OR      = 4'd10,
        OP_AND     = 4'd11,
        OP_XOR     = 4'd12,
        OP_ADD     = 4'd13,
        OP_SUB     = 4'd14,
        OP_SUBN    = 4'd15
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_RET_EMPTY   = 3'd1,
        ST_CALL_BAD    = 3'd2,
        ST_STACK_FULL  = 3'd3,
        ST_JUMP_BAD    = 3'd4
    } status_t;

    // what the data path decides for one operation
    typedef struct packed {
        logic             wr_vx;
        logic             wr_flag;
        logic [REG_W-1:0] vx_new;
        logic             flag_bit;
        logic             skip;
    } alu_res_t;

endpackage

`default_nettype wire

FILE: design/c8x_if.sv
// handshake channels of the execute block: command, result, configuration
// depends on c8x_pkg for field widths
`default_nettype none

// command word channel
interface c8x_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [c8x_pkg::OP_W-1:0]      op;
    logic [c8x_pkg::RIDX_W-1:0]    reg_x;
    logic [c8x_pkg::RIDX_W-1:0]    reg_y;
    logic [c8x_pkg::REG_W-1:0]     imm_byte;
    logic [c8x_pkg::ADDR_W-1:0]    target_addr;

    modport source (output valid, op, reg_x, reg_y, imm_byte, target_addr, input ready);
    modport sink (input valid, op, reg_x, reg_y, imm_byte, target_addr, output ready);
    modport monitor (input valid, ready, op, reg_x, reg_y, imm_byte, target_addr);
endinterface

// result word channel
interface c8x_res_if;
    logic                          valid;
    logic                          ready;
    logic [c8x_pkg::STATUS_W-1:0]  status;
    logic [c8x_pkg::PC_W-1:0]      pc_value;
    logic [c8x_pkg::REG_W-1:0]     vx_value;
    logic [c8x_pkg::REG_W-1:0]     flag_value;

    modport source (output valid, status, pc_value, vx_value, flag_value, input ready);
    modport sink (input valid, status, pc_value, vx_value, flag_value, output ready);
    modport monitor (input valid, ready, status, pc_value, vx_value, flag_value);
endinterface

// configuration write channel
interface c8x_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [c8x_pkg::SIZE_W-1:0]    program_bytes;

    modport source (output valid, program_bytes, input ready);
    modport sink (input valid, program_bytes, output ready);
    modport monitor (input valid, ready, program_bytes);
endinterface

`default_nettype wire

FILE: design/c8x_alu.sv
// register data path: load, move, add, subtract, logic ops, carry and borrow flags, skip tests
// depends on c8x_pkg
`default_nettype none

module c8x_alu (
    input  c8x_pkg::op_t                 op,
    input  logic [c8x_pkg::REG_W-1:0]    vx,
    input  logic [c8x_pkg::REG_W-1:0]    vy,
    input  logic [c8x_pkg::REG_W-1:0]    nn,
    output c8x_pkg::alu_res_t            res
);

    logic [c8x_pkg::REG_W:0] sum_vy;

    // carry out of vx + vy
    assign sum_vy = {1'b0, vx} + {1'b0, vy};

    // per-operation result and write enables
    always_comb
    begin
        res = '0;
        unique case (op)
            c8x_pkg::OP_RET, c8x_pkg::OP_JUMP, c8x_pkg::OP_CALL:
            begin
                res = '0;
            end
            c8x_pkg::OP_SKEQ_NN: res.skip = (vx == nn);
            c8x_pkg::OP_SKNE_NN: res.skip = (vx != nn);
            c8x_pkg::OP_SKEQ_VY: res.skip = (vx == vy);
            c8x_pkg::OP_SKNE_VY: res.skip = (vx != vy);
            c8x_pkg::OP_LOAD:
            begin
                res.wr_vx  = 1'b1;
                res.vx_new = nn;
            end
            c8x_pkg::OP_ADD_NN:
            begin
                res.wr_vx  = 1'b1;
                res.vx_new = vx + nn;
            end
            c8x_pkg::OP_MOVE:
            begin
                res.wr_vx  = 1'b1;
                res.vx_new = vy;
            end
            c8x_pkg::OP_OR:
            begin
                res.wr_vx  = 1'b1;
                res.vx_new = vx | vy;
            end
            c8x_pkg::OP_AND:
            begin
                res.wr_vx  = 1'b1;
                res.vx_new = vx & vy;
            end
            c8x_pkg::OP_XOR:
            begin
                res.wr_vx  = 1'b1;
                res.vx_new = vx ^ vy;
            end
            c8x_pkg::OP_ADD:
            begin
                res.wr_vx    = 1'b1;
                res.wr_flag  = 1'b1;
                res.vx_new   = sum_vy[c8x_pkg::REG_W-1:0];
                res.flag_bit = sum_vy[c8x_pkg::REG_W];
            end
            c8x_pkg::OP_SUB:
            begin
                res.wr_vx    = 1'b1;
                res.wr_flag  = 1'b1;
                res.vx_new   = vx - vy;
                res.flag_bit = (vx >= vy);
            end
            c8x_pkg::OP_SUBN:
            begin
                res.wr_vx    = 1'b1;
                res.wr_flag  = 1'b1;
                res.vx_new   = vy - vx;
                res.flag_bit = (vy >= vx);
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/chip8_control_alu_execute.sv
// top level of the chip8 execute block: register file, pc, return stack
// depends on c8x_pkg, c8x_if and c8x_alu
//
// usage:
//   cmd carries one decoded operation per word (op, reg_x, reg_y, imm_byte,
//   target_addr); res returns one word per command (status, pc_value,
//   vx_value, flag_value) in command order. cfg writes program_bytes, which
//   bounds jump and call targets and places the return stack right above
//   the program; write it only while no command is in flight. cfg.ready is
//   always high.
//   a command accepted on cmd passes the execute stage registers into the
//   output register. throughput: one command per cycle while res is not
//   held; each command reads the register file memory once (two ports) and
//   the return store once, a call also writes it; last writes are forwarded.
//   reset: all registers, the pc and the stack count go to zero, no result
//   is pending. the return store holds garbage until calls write it.
//   stall: while res is held the output register keeps its word; one more
//   command is accepted into the execute stage, then cmd.ready drops.
`default_nettype none

module chip8_control_alu_execute (
    input  logic       clk,
    input  logic       rst_n,
    c8x_cmd_if.sink    cmd,
    c8x_res_if.source  res,
    c8x_cfg_if.sink    cfg
);

    localparam int AW = c8x_pkg::STORE_AW;

    // architectural state
    logic [c8x_pkg::SIZE_W-1:0]  pb_reg;
    logic [c8x_pkg::PC_W-1:0]    pc_reg;
    logic [c8x_pkg::SIZE_W-1:0]  used_reg;
    logic [c8x_pkg::REG_W-1:0]   flag_reg;
    logic [c8x_pkg::NREGS-1:0]   rf_valid_reg;

    // memories
    logic [c8x_pkg::REG_W-1:0]   rf_mem [c8x_pkg::NREGS];
    logic [c8x_pkg::PC_W-1:0]    rs_mem [c8x_pkg::STORE_DEPTH];

    // execute stage
    logic                        s1_valid_reg;
    c8x_pkg::op_t                s1_op_reg;
    logic [c8x_pkg::RIDX_W-1:0]  s1_x_reg;
    logic [c8x_pkg::RIDX_W-1:0]  s1_y_reg;
    logic [c8x_pkg::REG_W-1:0]   s1_nn_reg;
    logic [c8x_pkg::ADDR_W-1:0]  s1_nnn_reg;
    logic [AW-1:0]               s1_ridx_reg;
    logic [c8x_pkg::REG_W-1:0]   rf_rdx_reg;
    logic [c8x_pkg::REG_W-1:0]   rf_rdy_reg;
    logic                        rf_okx_reg;
    logic                        rf_oky_reg;
    logic [c8x_pkg::PC_W-1:0]    rs_rd_reg;

    // last write of each memory, for forwarding
    logic                        rf_fwd_valid_reg;
    logic [c8x_pkg::RIDX_W-1:0]  rf_fwd_addr_reg;
    logic [c8x_pkg::REG_W-1:0]   rf_fwd_data_reg;
    logic                        rs_fwd_valid_reg;
    logic [AW-1:0]               rs_fwd_idx_reg;
    logic [c8x_pkg::PC_W-1:0]    rs_fwd_data_reg;

    // output register
    logic                        res_valid_reg;
    logic [c8x_pkg::STATUS_W-1:0] res_status_reg;
    logic [c8x_pkg::PC_W-1:0]    res_pc_reg;
    logic [c8x_pkg::REG_W-1:0]   res_vx_reg;
    logic [c8x_pkg::REG_W-1:0]   res_flag_reg;

    // combinational
    logic                        cmd_fire;
    logic                        s1_adv;
    logic [c8x_pkg::REG_W-1:0]   vx_mem;
    logic [c8x_pkg::REG_W-1:0]   vy_mem;
    logic [c8x_pkg::REG_W-1:0]   vx;
    logic [c8x_pkg::REG_W-1:0]   vy;
    logic [c8x_pkg::PC_W-1:0]    ret_addr;
    c8x_pkg::alu_res_t           alu;
    logic                        target_ok;
    logic [c8x_pkg::PC_W-1:0]    push_top;
    logic                        stack_full;
    c8x_pkg::status_t            status_new;
    logic [c8x_pkg::PC_W-1:0]    pc_new;
    logic [c8x_pkg::SIZE_W-1:0]  used_new;
    logic [c8x_pkg::REG_W-1:0]   flag_new;
    logic [c8x_pkg::REG_W-1:0]   vx_new;
    logic                        rs_we;
    logic                        rf_we;
    logic [c8x_pkg::SIZE_W-1:0]  used_next;
    logic [c8x_pkg::SIZE_W-1:0]  pop_used;
    logic [c8x_pkg::PC_W-1:0]    pop_top;
    logic [AW-1:0]               ridx_issue;

    // handshakes
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || s1_adv;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    // operands with forwarding of the last register write; v15 lives in flag_reg
    always_comb
    begin
        vx_mem = rf_okx_reg ? rf_rdx_reg : '0;
        if (rf_fwd_valid_reg && (rf_fwd_addr_reg == s1_x_reg))
        begin
            vx_mem = rf_fwd_data_reg;
        end
        vy_mem = rf_oky_reg ? rf_rdy_reg : '0;
        if (rf_fwd_valid_reg && (rf_fwd_addr_reg == s1_y_reg))
        begin
            vy_mem = rf_fwd_data_reg;
        end
        vx = (s1_x_reg == c8x_pkg::FLAG_REG) ? flag_reg : vx_mem;
        vy = (s1_y_reg == c8x_pkg::FLAG_REG) ? flag_reg : vy_mem;
    end

    // return address with forwarding of the last push
    assign ret_addr = (rs_fwd_valid_reg && (rs_fwd_idx_reg == s1_ridx_reg))
                      ? rs_fwd_data_reg : rs_rd_reg;

    c8x_alu u_alu (
        .op  (s1_op_reg),
        .vx  (vx),
        .vy  (vy),
        .nn  (s1_nn_reg),
        .res (alu)
    );

    // target bound and stack room tests
    assign target_ok  = (pb_reg >= c8x_pkg::STEP_SIZE) &&
                        ({1'b0, s1_nnn_reg} <= (pb_reg - c8x_pkg::STEP_SIZE));
    assign push_top   = {3'b000, used_reg} + {3'b000, pb_reg};
    assign stack_full = {1'b0, push_top} > c8x_pkg::STACK_LIMIT;

    // control flow and stack
    always_comb
    begin
        status_new = c8x_pkg::ST_OK;
        pc_new     = pc_reg;
        used_new   = used_reg;
        rs_we      = 1'b0;
        unique case (s1_op_reg)
            c8x_pkg::OP_RET:
            begin
                if (used_reg == '0)
                begin
                    status_new = c8x_pkg::ST_RET_EMPTY;
                end
                else
                begin
                    used_new = used_reg - c8x_pkg::STEP_SIZE;
                    pc_new   = ret_addr;
                end
            end
            c8x_pkg::OP_JUMP:
            begin
                if (!target_ok)
                begin
                    status_new = c8x_pkg::ST_JUMP_BAD;
                end
                else
                begin
                    pc_new = {4'h0, s1_nnn_reg};
                end
            end
            c8x_pkg::OP_CALL:
            begin
                if (!target_ok)
                begin
                    status_new = c8x_pkg::ST_CALL_BAD;
                end
                else if (stack_full)
                begin
                    status_new = c8x_pkg::ST_STACK_FULL;
                end
                else
                begin
                    rs_we    = 1'b1;
                    used_new = used_reg + c8x_pkg::STEP_SIZE;
                    pc_new   = {4'h0, s1_nnn_reg};
                end
            end
            default:
            begin
                if (alu.skip)
                begin
                    pc_new = pc_reg + c8x_pkg::STEP_BYTES;
                end
            end
        endcase
    end

    // flag first, then vx; vx wins when x is the flag register
    always_comb
    begin
        flag_new = flag_reg;
        if (alu.wr_flag)
        begin
            flag_new = {7'b0, alu.flag_bit};
        end
        if (alu.wr_vx && (s1_x_reg == c8x_pkg::FLAG_REG))
        begin
            flag_new = alu.vx_new;
        end
        vx_new = alu.wr_vx ? alu.vx_new : vx;
    end

    assign rf_we = s1_adv && alu.wr_vx && (s1_x_reg != c8x_pkg::FLAG_REG);

    // stack count as the next command will see it, and its pop address
    assign used_next  = s1_adv ? used_new : used_reg;
    assign pop_used   = used_next - c8x_pkg::STEP_SIZE;
    assign pop_top    = {3'b000, pop_used} + {3'b000, pb_reg};
    assign ridx_issue = pop_top[AW:1];

    // memories: one write and registered reads
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[s1_x_reg] <= vx_new;
        end
        if (s1_adv && rs_we)
        begin
            rs_mem[push_top[AW:1]] <= pc_reg + c8x_pkg::STEP_BYTES;
        end
        if (cmd_fire)
        begin
            rf_rdx_reg <= rf_mem[cmd.reg_x];
            rf_rdy_reg <= rf_mem[cmd.reg_y];
            rs_rd_reg  <= rs_mem[ridx_issue];
        end
    end

    // execute stage payload and output payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_op_reg   <= c8x_pkg::op_t'(cmd.op);
            s1_x_reg    <= cmd.reg_x;
            s1_y_reg    <= cmd.reg_y;
            s1_nn_reg   <= cmd.imm_byte;
            s1_nnn_reg  <= cmd.target_addr;
            s1_ridx_reg <= ridx_issue;
        end
        if (s1_adv)
        begin
            res_status_reg <= status_new;
            res_pc_reg     <= pc_new;
            res_vx_reg     <= vx_new;
            res_flag_reg   <= flag_new;
        end
        if (s1_adv && alu.wr_vx)
        begin
            rf_fwd_addr_reg <= s1_x_reg;
            rf_fwd_data_reg <= vx_new;
        end
        if (s1_adv && rs_we)
        begin
            rs_fwd_idx_reg  <= push_top[AW:1];
            rs_fwd_data_reg <= pc_reg + c8x_pkg::STEP_BYTES;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg           <= '0;
            pc_reg           <= '0;
            used_reg         <= '0;
            flag_reg         <= '0;
            rf_valid_reg     <= '0;
            rf_okx_reg       <= 1'b0;
            rf_oky_reg       <= 1'b0;
            rf_fwd_valid_reg <= 1'b0;
            rs_fwd_valid_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                pb_reg <= cfg.program_bytes;
            end
            if (cmd_fire)
            begin
                rf_okx_reg <= rf_valid_reg[cmd.reg_x];
                rf_oky_reg <= rf_valid_reg[cmd.reg_y];
            end
            if (s1_adv)
            begin
                pc_reg   <= pc_new;
                used_reg <= used_new;
                flag_reg <= flag_new;
            end
            if (rf_we)
            begin
                rf_valid_reg[s1_x_reg] <= 1'b1;
            end
            // forward only memory entries; the flag register is a flop
            if (s1_adv && alu.wr_vx)
            begin
                rf_fwd_valid_reg <= (s1_x_reg != c8x_pkg::FLAG_REG);
            end
            if (s1_adv && rs_we)
            begin
                rs_fwd_valid_reg <= 1'b1;
            end
            if (cmd_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result port
    assign res.valid      = res_valid_reg;
    assign res.status     = res_status_reg;
    assign res.pc_value   = res_pc_reg;
    assign res.vx_value   = res_vx_reg;
    assign res.flag_value = res_flag_reg;

endmodule

`default_nettype wire

FILE: design/c8x_checker.sv
// port-level checks of the execute block, attached by bind
// depends on c8x_pkg and the assertion macro header
`default_nettype none
`include "chip8_control_alu_execute_assert.svh"

module c8x_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_ready,
    input  logic                          cfg_ready,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  logic [c8x_pkg::STATUS_W-1:0]  res_status,
    input  logic [c8x_pkg::PC_W-1:0]      res_pc_value,
    input  logic [c8x_pkg::REG_W-1:0]     res_vx_value,
    input  logic [c8x_pkg::REG_W-1:0]     res_flag_value
);

    logic [c8x_pkg::PC_W-1:0]  last_pc_reg;
    logic [c8x_pkg::REG_W-1:0] last_flag_reg;
    logic [c8x_pkg::PC_W-1:0]  last_pc_next;
    logic [c8x_pkg::REG_W-1:0] last_flag_next;
    logic [c8x_pkg::STATUS_W+c8x_pkg::PC_W+2*c8x_pkg::REG_W-1:0] res_word;
    logic                      res_err;

    // whole result word and its error marker
    assign res_word = {res_status, res_pc_value, res_vx_value, res_flag_value};
    assign res_err  = res_valid && (res_status != c8x_pkg::ST_OK);

    // pc and flag of the last delivered word; both start at zero after reset
    always_comb
    begin
        last_pc_next   = last_pc_reg;
        last_flag_next = last_flag_reg;
        if (res_valid && res_ready)
        begin
            last_pc_next   = res_pc_value;
            last_flag_next = res_flag_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pc_reg   <= '0;
            last_flag_reg <= '0;
        end
        else
        begin
            last_pc_reg   <= last_pc_next;
            last_flag_reg <= last_flag_next;
        end
    end

    // a held result word keeps its contents
    `C8X_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_word))

    // a failed operation leaves the pc where the previous word had it
    `C8X_ASSERT_IMPL(a_err_pc, clk, rst_n, res_err, res_pc_value == last_pc_reg)

    // a failed operation leaves the flag register alone
    `C8X_ASSERT_IMPL(a_err_flag, clk, rst_n, res_err, res_flag_value == last_flag_reg)

    // with no result pending the block always takes a command
    `C8X_ASSERT_IMPL(a_cmd_free, clk, rst_n, !res_valid, cmd_ready && cfg_ready)

endmodule

bind chip8_control_alu_execute c8x_checker u_c8x_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_ready      (cmd.ready),
    .cfg_ready      (cfg.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_status     (res.status),
    .res_pc_value   (res.pc_value),
    .res_vx_value   (res.vx_value),
    .res_flag_value (res.flag_value)
);

`default_nettype wire
